@@ src/ibe_pkg.sv @@
// ----------------------------------------------------------------------------
// ibe_pkg
// Shared types and instruction kind codes for the x86 instruction byte emitter.
// ----------------------------------------------------------------------------
package ibe_pkg;

	localparam int MAX_BYTES = 7;

	localparam logic [4:0] KIND_ADD_I8    = 5'd0;
	localparam logic [4:0] KIND_ADD_I32   = 5'd1;
	localparam logic [4:0] KIND_CALL_REG  = 5'd2;
	localparam logic [4:0] KIND_CALL_REL  = 5'd3;
	localparam logic [4:0] KIND_INC       = 5'd4;
	localparam logic [4:0] KIND_JMP_REL   = 5'd5;
	localparam logic [4:0] KIND_MOV_RR    = 5'd6;
	localparam logic [4:0] KIND_MOV_R8_I8 = 5'd7;
	localparam logic [4:0] KIND_MOV_I32   = 5'd8;
	localparam logic [4:0] KIND_NOP       = 5'd9;
	localparam logic [4:0] KIND_POP       = 5'd10;
	localparam logic [4:0] KIND_PUSH_R    = 5'd11;
	localparam logic [4:0] KIND_PUSH_I8   = 5'd12;
	localparam logic [4:0] KIND_PUSH_I32  = 5'd13;
	localparam logic [4:0] KIND_RETN      = 5'd14;
	localparam logic [4:0] KIND_SETNZ     = 5'd15;
	localparam logic [4:0] KIND_SETZ      = 5'd16;
	localparam logic [4:0] KIND_SUB_RR    = 5'd17;
	localparam logic [4:0] KIND_SUB_I8    = 5'd18;
	localparam logic [4:0] KIND_SUB_I32   = 5'd19;
	localparam logic [4:0] KIND_TEST      = 5'd20;
	localparam logic [4:0] KIND_XOR_RR    = 5'd21;
	localparam logic [4:0] KIND_ABS       = 5'd22;
	localparam logic [4:0] KIND_FRAME     = 5'd23;
	localparam logic [4:0] KIND_FRAME_EXIT = 5'd24;
	localparam logic [4:0] KIND_REP_MOVSB = 5'd25;
	localparam logic [4:0] KIND_REP_MOVSD = 5'd26;
	localparam logic [4:0] KIND_REP_STOSB = 5'd27;
	localparam logic [4:0] KIND_REP_STOSD = 5'd28;

	typedef struct packed {
		logic [4:0]  kind;
		logic [2:0]  reg_dst;
		logic [2:0]  reg_src;
		logic [31:0] immediate;
		logic [31:0] target_address;
	} ibe_in_t;

	typedef struct packed {
		logic [7:0]  code_byte;
		logic [31:0] byte_offset;
		logic        last_byte;
	} ibe_out_t;

	// One encoded instruction waiting in the queue
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                cnt;
		logic [31:0]               start;
	} ibe_entry_t;

	// Queue handshake between front and back
	typedef struct packed {
		logic full;
		logic empty;
	} ibe_q_status_t;

endpackage

@@ src/ibe_queue.sv @@
// ----------------------------------------------------------------------------
// ibe_queue
// Small register FIFO of encoded instructions between front and back.
// ----------------------------------------------------------------------------
module ibe_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ibe_pkg::ibe_entry_t push_data,
	input  logic                pop,
	output ibe_pkg::ibe_entry_t head,
	output ibe_pkg::ibe_q_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ibe_pkg::ibe_entry_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1))
			return '0;
		return p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (cnt_q == CW'(DEPTH));
	assign status.empty = (cnt_q == '0);

endmodule

@@ src/ibe_front.sv @@
// ----------------------------------------------------------------------------
// ibe_front
// Decodes one instruction request into its byte string and start offset.
// ----------------------------------------------------------------------------
module ibe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  ibe_pkg::ibe_in_t    req,
	input  logic [31:0]         base_address,
	output logic                push,
	output ibe_pkg::ibe_entry_t entry
);

	logic [31:0] off_q;
	logic [31:0] disp;
	logic [ibe_pkg::MAX_BYTES-1:0][7:0] b;
	logic [2:0]  n;
	logic [2:0]  d, s;
	logic [7:0]  i8;
	logic [31:0] i32;
	logic [15:0] w16;

	assign d    = req.reg_dst;
	assign s    = req.reg_src;
	assign i8   = req.immediate[7:0];
	assign i32  = req.immediate;
	assign w16  = {req.immediate[13:0], 2'b00};
	// rel32 is measured from the end of the 5-byte instruction
	assign disp = req.target_address - base_address - off_q - 32'd5;

	always_comb begin
		b = '0;
		n = 3'd0;
		unique case (req.kind)
			ibe_pkg::KIND_ADD_I8:    begin b[0]=8'h83; b[1]={5'b11000,d}; b[2]=i8; n=3'd3; end
			ibe_pkg::KIND_ADD_I32:   begin
				b[0]=8'h81; b[1]={5'b11000,d};
				b[2]=i32[7:0]; b[3]=i32[15:8]; b[4]=i32[23:16]; b[5]=i32[31:24]; n=3'd6;
			end
			ibe_pkg::KIND_CALL_REG:  begin b[0]=8'hFF; b[1]={5'b11010,d}; n=3'd2; end
			ibe_pkg::KIND_CALL_REL,
			ibe_pkg::KIND_JMP_REL:   begin
				b[0] = (req.kind == ibe_pkg::KIND_CALL_REL) ? 8'hE8 : 8'hE9;
				b[1]=disp[7:0]; b[2]=disp[15:8]; b[3]=disp[23:16]; b[4]=disp[31:24]; n=3'd5;
			end
			ibe_pkg::KIND_INC:       begin b[0]={5'b01000,d}; n=3'd1; end
			ibe_pkg::KIND_MOV_RR:    begin b[0]=8'h8B; b[1]={2'b11,d,s}; n=3'd2; end
			ibe_pkg::KIND_MOV_R8_I8: begin b[0]={5'b10110,d}; b[1]=i8; n=3'd2; end
			ibe_pkg::KIND_MOV_I32:   begin
				b[0]={5'b10111,d};
				b[1]=i32[7:0]; b[2]=i32[15:8]; b[3]=i32[23:16]; b[4]=i32[31:24]; n=3'd5;
			end
			ibe_pkg::KIND_NOP:       begin b[0]=8'h90; n=3'd1; end
			ibe_pkg::KIND_POP:       begin b[0]={5'b01011,d}; n=3'd1; end
			ibe_pkg::KIND_PUSH_R:    begin b[0]={5'b01010,d}; n=3'd1; end
			ibe_pkg::KIND_PUSH_I8:   begin b[0]=8'h6A; b[1]=i8; n=3'd2; end
			ibe_pkg::KIND_PUSH_I32:  begin
				b[0]=8'h68;
				b[1]=i32[7:0]; b[2]=i32[15:8]; b[3]=i32[23:16]; b[4]=i32[31:24]; n=3'd5;
			end
			ibe_pkg::KIND_RETN:      begin
				if (i32 == '0) begin
					b[0]=8'hC3; n=3'd1;
				end else begin
					b[0]=8'hC2; b[1]=w16[7:0]; b[2]=w16[15:8]; n=3'd3;
				end
			end
			ibe_pkg::KIND_SETNZ:     begin b[0]=8'h0F; b[1]=8'h95; b[2]={5'b11000,d}; n=3'd3; end
			ibe_pkg::KIND_SETZ:      begin b[0]=8'h0F; b[1]=8'h94; b[2]={5'b11000,d}; n=3'd3; end
			ibe_pkg::KIND_SUB_RR:    begin b[0]=8'h2B; b[1]={2'b11,d,s}; n=3'd2; end
			ibe_pkg::KIND_SUB_I8:    begin b[0]=8'h83; b[1]={5'b11101,d}; b[2]=i8; n=3'd3; end
			ibe_pkg::KIND_SUB_I32:   begin
				b[0]=8'h81; b[1]={5'b11101,d};
				b[2]=i32[7:0]; b[3]=i32[15:8]; b[4]=i32[23:16]; b[5]=i32[31:24]; n=3'd6;
			end
			ibe_pkg::KIND_TEST:      begin b[0]=8'h85; b[1]={2'b11,d,d}; n=3'd2; end
			ibe_pkg::KIND_XOR_RR:    begin b[0]=8'h33; b[1]={2'b11,d,s}; n=3'd2; end
			ibe_pkg::KIND_ABS:       begin
				// eax is the implied operand; copy first unless already there
				if (d != 3'd0) begin
					b[0]=8'h8B; b[1]={5'b11000,d};
					b[2]=8'h99; b[3]=8'h33; b[4]=8'hC2; b[5]=8'h2B; b[6]=8'hC2; n=3'd7;
				end else begin
					b[0]=8'h99; b[1]=8'h33; b[2]=8'hC2; b[3]=8'h2B; b[4]=8'hC2; n=3'd5;
				end
			end
			ibe_pkg::KIND_FRAME:     begin b[0]=8'h55; b[1]=8'h8B; b[2]=8'hEC; n=3'd3; end
			ibe_pkg::KIND_FRAME_EXIT: begin b[0]=8'h8B; b[1]=8'hE5; b[2]=8'h5D; n=3'd3; end
			ibe_pkg::KIND_REP_MOVSB: begin b[0]=8'hF3; b[1]=8'hA4; n=3'd2; end
			ibe_pkg::KIND_REP_MOVSD: begin b[0]=8'hF3; b[1]=8'hA5; n=3'd2; end
			ibe_pkg::KIND_REP_STOSB: begin b[0]=8'hF3; b[1]=8'hAA; n=3'd2; end
			ibe_pkg::KIND_REP_STOSD: begin b[0]=8'hF3; b[1]=8'hAB; n=3'd2; end
			default:                 begin b = '0; n = 3'd0; end
		endcase
	end

	// Undefined kinds produce nothing and are dropped here
	assign push        = accept && (n != 3'd0);
	assign entry.bytes = b;
	assign entry.cnt   = n;
	assign entry.start = off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			off_q <= '0;
		else if (push)
			off_q <= off_q + {29'd0, n};
	end

endmodule

@@ src/ibe_back.sv @@
// ----------------------------------------------------------------------------
// ibe_back
// Serializes the queue head one byte per cycle into the output register, while the receiver does not stall.
// ----------------------------------------------------------------------------
module ibe_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ibe_pkg::ibe_entry_t    head,
	input  ibe_pkg::ibe_q_status_t status,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output ibe_pkg::ibe_out_t      out_data
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	ibe_pkg::ibe_out_t out_q;
	logic       adv;
	logic       last;

	assign adv  = (!out_valid_q || !out_stall) && !status.empty;
	assign last = (idx_q == head.cnt - 3'd1);
	assign pop  = adv && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv)
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
			if (adv)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.code_byte   <= head.bytes[idx_q];
			out_q.byte_offset <= head.start + {29'd0, idx_q};
			out_q.last_byte   <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ src/x86_instruction_byte_emitter_unit.sv @@
// ----------------------------------------------------------------------------
// x86_instruction_byte_emitter_unit
// x86-32 instruction encoder: one request in, its machine code bytes out.
// ----------------------------------------------------------------------------
// Usage:
//  - in channel (in_valid/in_stall/in_data): one transaction per instruction
//    request. Accepted when in_valid is high and in_stall low.
//  - out channel (out_valid/out_stall/out_data): one transaction per emitted
//    byte, with its buffer offset and last_byte set on the final byte.
//  - cfg_wr_en/cfg_wr_data write base_address; write only while idle.
// Path: decode is combinational into the queue; the first byte of a request
//  then goes from the queue head through the output register before it shows
//  on out_valid.
// Throughput: one byte per cycle from the back end while out_stall is low; a
//  request yields 1 to 7 bytes. The front accepts a new request every
//  cycle while the queue has room, so short forms stream back to back.
// Undefined kinds (29..31) are accepted and produce no bytes.
// Reset clears the write offset, base_address, queue and output valid.
// When the receiver stalls, the output register holds its byte, the back end
//  stops, and once the queue fills in_stall rises.
// ----------------------------------------------------------------------------
module x86_instruction_byte_emitter_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ibe_pkg::ibe_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output ibe_pkg::ibe_out_t out_data,
	input  logic              cfg_wr_en,
	input  logic [31:0]       cfg_wr_data
);

	logic [31:0]            base_address_q;
	logic                   in_accept;
	logic                   push;
	logic                   pop;
	ibe_pkg::ibe_entry_t    push_entry;
	ibe_pkg::ibe_entry_t    head;
	ibe_pkg::ibe_q_status_t q_status;

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			base_address_q <= '0;
		else if (cfg_wr_en)
			base_address_q <= cfg_wr_data;
	end

	// Front stalls only on a full queue
	assign in_stall  = q_status.full;
	assign in_accept = in_valid && !in_stall;

	ibe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_accept),
		.req          (in_data),
		.base_address (base_address_q),
		.push         (push),
		.entry        (push_entry)
	);

	ibe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	ibe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.status    (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Byte offsets on the output form one unbroken running sequence
	a_offset_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=>
			!out_valid || out_data.byte_offset == $past(out_data.byte_offset) + 32'd1)
		else $error("output byte offset skipped or repeated");

	// A defined kind always lands in the queue
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && in_data.kind <= ibe_pkg::KIND_REP_STOSD |=> !q_status.empty)
		else $error("accepted instruction lost before queue");

	// Undefined kinds never enter the queue
	a_no_push_undef: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> in_accept && in_data.kind <= ibe_pkg::KIND_REP_STOSD)
		else $error("queue push without a defined instruction");

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for x86_instruction_byte_emitter_unit. Requests go in
// through the input channel, and every emitted byte is compared with a local
// encoder model that keeps its own write offset and base address.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          RESET_CYCLES = 8;
	localparam int          DRAIN_TAIL   = 8;
	localparam int          MAX_REPORTS  = 10;
	localparam int          PHASE_ITEMS  = 35;
	localparam logic [2:0]  REG_EAX      = 3'd0;
	localparam logic [2:0]  REG_EDI      = 3'd7;
	localparam logic [4:0]  KIND_UNUSED_FIRST = 5'd29;
	localparam logic [4:0]  KIND_UNUSED_LAST  = 5'd31;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	ibe_pkg::ibe_in_t  in_data;
	logic              out_valid;
	logic              out_stall = 1'b0;
	ibe_pkg::ibe_out_t out_data;
	logic              cfg_wr_en;
	logic [31:0]       cfg_wr_data;

	// Encoder model state
	logic [31:0]       model_base;
	logic [31:0]       next_offset;
	logic [7:0]        code_buf[$];
	ibe_pkg::ibe_out_t pending_bytes[$];

	// Run bookkeeping
	int mismatches;
	int requests_sent;
	int undefined_sent;
	int bytes_checked;
	int base_writes;

	// Idle controls shared with the receiver process
	bit tx_idle_on;
	bit rx_idle_on;
	int hold_request;
	int stall_left = 0;

	x86_instruction_byte_emitter_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Encoder model
	// ------------------------------------------------------------------
	function automatic void emit_byte(input logic [7:0] v);
		code_buf.push_back(v);
	endfunction

	// little-endian dword
	function automatic void emit_dword(input logic [31:0] v);
		emit_byte(v[7:0]);
		emit_byte(v[15:8]);
		emit_byte(v[23:16]);
		emit_byte(v[31:24]);
	endfunction

	// Builds the byte sequence of one request and queues one expected
	// transaction per byte, advancing the model's write offset.
	task automatic encode_request(input ibe_pkg::ibe_in_t req);
		logic [31:0]       disp;
		logic [15:0]       ret_pop;
		logic [2:0]        d;
		logic [2:0]        s;
		ibe_pkg::ibe_out_t e;
		int                n;
		d = req.reg_dst;
		s = req.reg_src;
		// rel32 is measured from the end of the 5-byte instruction
		disp = req.target_address - (model_base + next_offset) - 32'd5;
		ret_pop = 16'(req.immediate << 2);
		code_buf.delete();
		case (req.kind)
			ibe_pkg::KIND_ADD_I8: begin
				emit_byte(8'h83); emit_byte({5'b11000, d}); emit_byte(req.immediate[7:0]);
			end
			ibe_pkg::KIND_ADD_I32: begin
				emit_byte(8'h81); emit_byte({5'b11000, d}); emit_dword(req.immediate);
			end
			ibe_pkg::KIND_CALL_REG: begin
				emit_byte(8'hFF); emit_byte({5'b11010, d});
			end
			ibe_pkg::KIND_CALL_REL: begin
				emit_byte(8'hE8); emit_dword(disp);
			end
			ibe_pkg::KIND_INC:       emit_byte(8'h40 | 8'(d));
			ibe_pkg::KIND_JMP_REL: begin
				emit_byte(8'hE9); emit_dword(disp);
			end
			ibe_pkg::KIND_MOV_RR: begin
				emit_byte(8'h8B); emit_byte({2'b11, d, s});
			end
			ibe_pkg::KIND_MOV_R8_I8: begin
				emit_byte(8'hB0 | 8'(d)); emit_byte(req.immediate[7:0]);
			end
			ibe_pkg::KIND_MOV_I32: begin
				emit_byte(8'hB8 | 8'(d)); emit_dword(req.immediate);
			end
			ibe_pkg::KIND_NOP:       emit_byte(8'h90);
			ibe_pkg::KIND_POP:       emit_byte(8'h58 | 8'(d));
			ibe_pkg::KIND_PUSH_R:    emit_byte(8'h50 | 8'(d));
			ibe_pkg::KIND_PUSH_I8: begin
				emit_byte(8'h6A); emit_byte(req.immediate[7:0]);
			end
			ibe_pkg::KIND_PUSH_I32: begin
				emit_byte(8'h68); emit_dword(req.immediate);
			end
			ibe_pkg::KIND_RETN: begin
				// zero count: plain near return; else pop count*4 bytes (16 bits)
				if (req.immediate == 32'd0) begin
					emit_byte(8'hC3);
				end else begin
					emit_byte(8'hC2); emit_byte(ret_pop[7:0]); emit_byte(ret_pop[15:8]);
				end
			end
			ibe_pkg::KIND_SETNZ: begin
				emit_byte(8'h0F); emit_byte(8'h95); emit_byte({5'b11000, d});
			end
			ibe_pkg::KIND_SETZ: begin
				emit_byte(8'h0F); emit_byte(8'h94); emit_byte({5'b11000, d});
			end
			ibe_pkg::KIND_SUB_RR: begin
				emit_byte(8'h2B); emit_byte({2'b11, d, s});
			end
			ibe_pkg::KIND_SUB_I8: begin
				emit_byte(8'h83); emit_byte({5'b11101, d}); emit_byte(req.immediate[7:0]);
			end
			ibe_pkg::KIND_SUB_I32: begin
				emit_byte(8'h81); emit_byte({5'b11101, d}); emit_dword(req.immediate);
			end
			ibe_pkg::KIND_TEST: begin
				emit_byte(8'h85); emit_byte({2'b11, d, d});
			end
			ibe_pkg::KIND_XOR_RR: begin
				emit_byte(8'h33); emit_byte({2'b11, d, s});
			end
			ibe_pkg::KIND_ABS: begin
				// mov eax,d is skipped when the operand already is eax
				if (d != REG_EAX) begin
					emit_byte(8'h8B); emit_byte({5'b11000, d});
				end
				emit_byte(8'h99);
				emit_byte(8'h33); emit_byte(8'hC2);
				emit_byte(8'h2B); emit_byte(8'hC2);
			end
			ibe_pkg::KIND_FRAME: begin
				emit_byte(8'h55); emit_byte(8'h8B); emit_byte(8'hEC);
			end
			ibe_pkg::KIND_FRAME_EXIT: begin
				emit_byte(8'h8B); emit_byte(8'hE5); emit_byte(8'h5D);
			end
			ibe_pkg::KIND_REP_MOVSB: begin
				emit_byte(8'hF3); emit_byte(8'hA4);
			end
			ibe_pkg::KIND_REP_MOVSD: begin
				emit_byte(8'hF3); emit_byte(8'hA5);
			end
			ibe_pkg::KIND_REP_STOSB: begin
				emit_byte(8'hF3); emit_byte(8'hAA);
			end
			ibe_pkg::KIND_REP_STOSD: begin
				emit_byte(8'hF3); emit_byte(8'hAB);
			end
			default: ;      // undefined kinds emit nothing
		endcase
		n = code_buf.size();
		if (n > ibe_pkg::MAX_BYTES)
			n = ibe_pkg::MAX_BYTES;
		for (int k = 0; k < n; k++) begin
			e.code_byte   = code_buf[k];
			e.byte_offset = next_offset;
			e.last_byte   = (k == n - 1);
			pending_bytes.push_back(e);
			next_offset = next_offset + 32'd1;
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic ibe_pkg::ibe_in_t make_req(input logic [4:0] kind,
			input logic [2:0] d, input logic [2:0] s, input logic [31:0] imm,
			input logic [31:0] tgt);
		ibe_pkg::ibe_in_t r;
		r.kind           = kind;
		r.reg_dst        = d;
		r.reg_src        = s;
		r.immediate      = imm;
		r.target_address = tgt;
		return r;
	endfunction

	// mostly back to back, sometimes a few cycles, rarely a long gap
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic ibe_pkg::ibe_in_t random_req(input bit defined_only);
		ibe_pkg::ibe_in_t r;
		int               sel;
		r.kind    = defined_only || $urandom_range(0, 9) != 0 ?
			5'($urandom_range(0, ibe_pkg::KIND_REP_STOSD)) :
			5'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
		r.reg_dst = 3'($urandom_range(0, 7));
		r.reg_src = 3'($urandom_range(0, 7));
		sel = $urandom_range(0, 7);
		// zero and small counts so RETN hits both encodings
		if (sel == 0)
			r.immediate = 32'd0;
		else if (sel == 1)
			r.immediate = 32'($urandom_range(1, 20));
		else
			r.immediate = $urandom;
		// near targets give short displacements in both directions
		if ($urandom_range(0, 1) == 0)
			r.target_address = $urandom;
		else
			r.target_address = model_base + next_offset + 32'($urandom_range(0, 512)) - 32'd256;
		return r;
	endfunction

	// Offers one transaction and holds it until accepted. Returns at a falling
	// edge with in_valid still high, so a following request needs no re-raise.
	task automatic send_request(input ibe_pkg::ibe_in_t req);
		int gap;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		encode_request(req);
		requests_sent++;
		if (req.kind > ibe_pkg::KIND_REP_STOSD)
			undefined_sent++;
		@(negedge clk);
	endtask

	// Stops offering and waits until every expected byte has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(negedge clk);
	endtask

	// Undefined kinds produce no bytes and never enter the queue; the tail
	// adds a margin after the last expected byte before the block is called idle.
	task automatic wait_idle();
		wait_drained();
		repeat (DRAIN_TAIL) @(negedge clk);
	endtask

	task automatic write_base(input logic [31:0] value);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		model_base  = value;
		base_writes++;
	endtask

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stall runs plus long hold-offs on request.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_request > 0) begin
			stall_left   = hold_request;
			hold_request = 0;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
			out_stall  <= 1'b1;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Output checker: each accepted byte against the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_byte
		ibe_pkg::ibe_out_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_bytes.size() == 0) begin
				log_mismatch($sformatf("unexpected byte %h at offset %h last %b",
					out_data.code_byte, out_data.byte_offset, out_data.last_byte));
			end else begin
				want = pending_bytes.pop_front();
				bytes_checked++;
				if (out_data.code_byte !== want.code_byte ||
						out_data.byte_offset !== want.byte_offset ||
						out_data.last_byte !== want.last_byte)
					log_mismatch($sformatf(
						"byte exp %h act %h, offset exp %h act %h, last exp %b act %b",
						want.code_byte, out_data.code_byte,
						want.byte_offset, out_data.byte_offset,
						want.last_byte, out_data.last_byte));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// every defined kind at least once, fields at their extremes
	task automatic test_each_kind();
		send_request(make_req(ibe_pkg::KIND_ADD_I8, REG_EDI, REG_EAX, 32'h0000_00FF, 32'h0));
		send_request(make_req(ibe_pkg::KIND_ADD_I32, REG_EAX, REG_EDI, 32'hFFFF_FFFF, 32'h0));
		send_request(make_req(ibe_pkg::KIND_CALL_REG, REG_EDI, REG_EDI, 32'h0, 32'hFFFF_FFFF));
		send_request(make_req(ibe_pkg::KIND_CALL_REL, REG_EAX, REG_EAX, 32'h0, 32'h0000_0000));
		send_request(make_req(ibe_pkg::KIND_INC, REG_EDI, REG_EAX, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_JMP_REL, REG_EAX, REG_EAX, 32'h0, 32'hFFFF_FFFF));
		send_request(make_req(ibe_pkg::KIND_MOV_RR, REG_EDI, REG_EAX, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_MOV_RR, REG_EAX, REG_EDI, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_MOV_R8_I8, 3'd3, REG_EAX, 32'hFFFF_FF80, 32'h0));
		send_request(make_req(ibe_pkg::KIND_MOV_I32, REG_EDI, REG_EAX, 32'h8000_0001, 32'h0));
		send_request(make_req(ibe_pkg::KIND_NOP, REG_EDI, REG_EDI, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		send_request(make_req(ibe_pkg::KIND_POP, REG_EDI, REG_EAX, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_PUSH_R, REG_EAX, REG_EAX, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_PUSH_I8, REG_EAX, REG_EAX, 32'h0000_007F, 32'h0));
		send_request(make_req(ibe_pkg::KIND_PUSH_I32, REG_EAX, REG_EAX, 32'h1234_5678, 32'h0));
		send_request(make_req(ibe_pkg::KIND_RETN, REG_EAX, REG_EAX, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_SETNZ, REG_EDI, REG_EAX, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_SETZ, REG_EAX, REG_EDI, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_SUB_RR, 3'd5, 3'd3, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_SUB_I8, REG_EDI, REG_EAX, 32'hFFFF_FF00, 32'h0));
		send_request(make_req(ibe_pkg::KIND_SUB_I32, 3'd2, REG_EAX, 32'hA5A5_A5A5, 32'h0));
		send_request(make_req(ibe_pkg::KIND_TEST, REG_EDI, REG_EAX, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_XOR_RR, REG_EDI, REG_EDI, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_ABS, REG_EDI, REG_EAX, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_FRAME, REG_EAX, REG_EAX, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_FRAME_EXIT, REG_EAX, REG_EAX, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_REP_MOVSB, REG_EAX, REG_EAX, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_REP_MOVSD, REG_EAX, REG_EAX, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_REP_STOSB, REG_EAX, REG_EAX, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_REP_STOSD, REG_EAX, REG_EAX, 32'h0, 32'h0));
	endtask

	// RETN count encodings, ABS on eax, and undefined kinds
	task automatic test_special_cases();
		send_request(make_req(ibe_pkg::KIND_RETN, REG_EAX, REG_EAX, 32'h0000_0001, 32'h0));
		// count*4 overflows 16 bits to zero but still uses the C2 form
		send_request(make_req(ibe_pkg::KIND_RETN, REG_EAX, REG_EAX, 32'h0000_4000, 32'h0));
		send_request(make_req(ibe_pkg::KIND_RETN, REG_EDI, REG_EDI, 32'hFFFF_FFFF, 32'h0));
		send_request(make_req(ibe_pkg::KIND_ABS, REG_EAX, REG_EDI, 32'h0, 32'h0));
		send_request(make_req(KIND_UNUSED_LAST, REG_EDI, REG_EDI, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		send_request(make_req(KIND_UNUSED_FIRST, REG_EAX, REG_EAX, 32'h0, 32'h0));
		send_request(make_req(ibe_pkg::KIND_NOP, REG_EAX, REG_EAX, 32'h0, 32'h0));
	endtask

	// rel32 math with base at the extremes, wrapping the address sum
	task automatic test_rel_branch_base();
		write_base(32'hFFFF_FFFF);
		send_request(make_req(ibe_pkg::KIND_CALL_REL, REG_EAX, REG_EAX, 32'h0, 32'h0000_0000));
		send_request(make_req(ibe_pkg::KIND_JMP_REL, REG_EAX, REG_EAX, 32'h0, 32'h0000_0005));
		send_request(make_req(ibe_pkg::KIND_CALL_REL, REG_EAX, REG_EAX, 32'h0,
			model_base + next_offset + 32'd5));
		write_base(32'h8000_0000);
		send_request(make_req(ibe_pkg::KIND_JMP_REL, REG_EAX, REG_EAX, 32'h0, 32'h7FFF_FFFF));
		send_request(make_req(ibe_pkg::KIND_CALL_REL, REG_EAX, REG_EAX, 32'h0, $urandom));
		write_base($urandom);
		send_request(make_req(ibe_pkg::KIND_JMP_REL, REG_EAX, REG_EAX, 32'h0, $urandom));
		send_request(make_req(ibe_pkg::KIND_CALL_REL, REG_EAX, REG_EAX, 32'h0, model_base));
		write_base(32'h0000_0000);
		send_request(make_req(ibe_pkg::KIND_JMP_REL, REG_EAX, REG_EAX, 32'h0, 32'hFFFF_FFFF));
	endtask

	// random streams, one base setting per phase; one phase without idling
	task automatic test_random_stream();
		ibe_pkg::ibe_in_t req;
		int               defined_cnt;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_base(32'h0000_0000);
				1: write_base(32'hFFFF_FFFF);
				default: write_base($urandom);
			endcase
			tx_idle_on = (phase != 2);
			rx_idle_on = (phase != 2);
			defined_cnt = 0;
			while (defined_cnt < PHASE_ITEMS) begin
				req = random_req(1'b0);
				send_request(req);
				if (req.kind <= ibe_pkg::KIND_REP_STOSD)
					defined_cnt++;
			end
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// long receiver hold-off while the sender keeps pushing, then a pause
	// until the output side has caught up completely, then six more requests
	task automatic test_backpressure();
		tx_idle_on   = 1'b0;
		hold_request = 80;
		for (int k = 0; k < 16; k++)
			send_request(random_req(1'b1));
		wait_drained();
		tx_idle_on = 1'b1;
		for (int k = 0; k < 6; k++)
			send_request(random_req(1'b1));
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		model_base   = '0;
		next_offset  = '0;
		mismatches   = 0;
		requests_sent = 0;
		undefined_sent = 0;
		bytes_checked = 0;
		base_writes  = 0;
		tx_idle_on   = 1'b1;
		rx_idle_on   = 1'b1;
		hold_request = 0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_each_kind();
		test_special_cases();
		test_rel_branch_base();
		test_backpressure();
		test_random_stream();

		wait_idle();
		if (pending_bytes.size() != 0)
			log_mismatch($sformatf("%0d expected bytes never arrived", pending_bytes.size()));

		$display("Run covered %0d requests (%0d with undefined kinds), %0d code bytes checked,",
			requests_sent, undefined_sent, bytes_checked);
		$display("  %0d base address writes, receiver hold-offs and sender pauses.", base_writes);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("FAILED: results differ");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10ms;
		$display("timeout with %0d bytes outstanding", pending_bytes.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
